### hw/rtl/vn_pkg.sv
// Shared types and constants for the vector normalization pipeline.
package vn_pkg;

   localparam int COMP_W     = 32;
   localparam int SUM_W      = 64;
   localparam int SQRT_STEPS = 32;
   localparam int DIV_STEPS  = 31;
   localparam int LANES      = 3;

   localparam logic [DIV_STEPS-1:0] UNIT_ONE = DIV_STEPS'(32'h4000_0000);

   typedef struct packed {
      logic [LANES-1:0][COMP_W-1:0] mag;
      logic [LANES-1:0]             neg;
   } side_type;

endpackage

### hw/rtl/vec3_normalize.sv
// Top level of the vector normalization pipeline: unit vector and length per word.
//
//   Channel   Handshake            Ports
//   request   start & !busy        req_comp_x, req_comp_y, req_comp_z
//   response  rsp_valid strobe     rsp_unit_x, rsp_unit_y, rsp_unit_z, rsp_vector_length
//
// One word is taken every cycle; busy is always low.
// Each word passes from request to response through three front stages
// (magnitude, squares, sum), 32 square root stages, 31 divider stages and the output register.
// Words leave in the order they came, each strobed for exactly one cycle.
// Reset clears all valid bits, so words in flight are dropped.
// The receiver cannot stall, so nothing in the pipeline ever holds.
module vec3_normalize (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic signed [vn_pkg::COMP_W-1:0]  req_comp_x,
   input  logic signed [vn_pkg::COMP_W-1:0]  req_comp_y,
   input  logic signed [vn_pkg::COMP_W-1:0]  req_comp_z,
   output logic                              rsp_valid,
   output logic signed [vn_pkg::COMP_W-1:0]  rsp_unit_x,
   output logic signed [vn_pkg::COMP_W-1:0]  rsp_unit_y,
   output logic signed [vn_pkg::COMP_W-1:0]  rsp_unit_z,
   output logic        [vn_pkg::COMP_W-1:0]  rsp_vector_length
);
   import vn_pkg::*;

   localparam int LATENCY = 3 + SQRT_STEPS + DIV_STEPS + 1;

   logic                        accept;
   logic [LANES-1:0][COMP_W-1:0] comp;

   logic                          s1_valid_ff;
   side_type                      s1_side_ff;
   side_type                      s1_side_in;
   logic                          s2_valid_ff;
   side_type                      s2_side_ff;
   logic [LANES-1:0][SUM_W-1:0]   s2_sq_ff;
   logic                          s3_valid_ff;
   side_type                      s3_side_ff;
   logic [SUM_W-1:0]              s3_sum_ff;

   logic                          sq_valid;
   logic [COMP_W-1:0]             sq_len;
   side_type                      sq_side;

   logic                          dv_valid;
   logic [COMP_W-1:0]             dv_len;
   logic [LANES-1:0]              dv_neg;
   logic [LANES-1:0][DIV_STEPS-1:0] dv_quot;

   logic                          out_valid_ff;
   logic [LANES-1:0][COMP_W-1:0]  out_unit_ff;
   logic [LANES-1:0][COMP_W-1:0]  out_unit_in;
   logic [COMP_W-1:0]             out_len_ff;

   assign busy   = 1'b0;
   assign accept = start & ~busy;
   assign comp   = {req_comp_z, req_comp_y, req_comp_x};

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         s1_side_in.neg[l] = comp[l][COMP_W-1];
         s1_side_in.mag[l] = comp[l][COMP_W-1] ? (~comp[l] + 1'b1) : comp[l];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
      s1_side_ff <= s1_side_in;
      s2_side_ff <= s1_side_ff;
      for (int l = 0; l < LANES; l++) begin
         s2_sq_ff[l] <= SUM_W'(s1_side_ff.mag[l]) * SUM_W'(s1_side_ff.mag[l]);
      end
      s3_side_ff <= s2_side_ff;
      s3_sum_ff  <= s2_sq_ff[0] + s2_sq_ff[1] + s2_sq_ff[2];
   end

   vn_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s3_valid_ff),
      .in_sum    (s3_sum_ff),
      .in_side   (s3_side_ff),
      .out_valid (sq_valid),
      .out_len   (sq_len),
      .out_side  (sq_side)
   );

   vn_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sq_valid),
      .in_len    (sq_len),
      .in_side   (sq_side),
      .out_valid (dv_valid),
      .out_len   (dv_len),
      .out_neg   (dv_neg),
      .out_quot  (dv_quot)
   );

   always_comb begin
      logic [DIV_STEPS-1:0] q;
      for (int l = 0; l < LANES; l++) begin
         q = (dv_quot[l] > UNIT_ONE) ? UNIT_ONE : dv_quot[l];
         if (dv_len == '0) begin
            out_unit_in[l] = '0;
         end else if (dv_neg[l]) begin
            out_unit_in[l] = ~{1'b0, q} + 1'b1;
         end else begin
            out_unit_in[l] = {1'b0, q};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= dv_valid;
      end
      out_unit_ff <= out_unit_in;
      out_len_ff  <= dv_len;
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_unit_x        = out_unit_ff[0];
   assign rsp_unit_y        = out_unit_ff[1];
   assign rsp_unit_z        = out_unit_ff[2];
   assign rsp_vector_length = out_len_ff;

   a_latency : assert property (@(posedge clock) disable iff (reset)
      accept |-> ##LATENCY rsp_valid)
      else $error("word did not reach the response on time");

   a_no_spurious : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, LATENCY))
      else $error("response without a matching request");

   a_zero_len : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_vector_length == '0) |->
         (rsp_unit_x == '0 && rsp_unit_y == '0 && rsp_unit_z == '0))
      else $error("zero length with nonzero unit vector");

   a_unit_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_unit_x <= $signed({2'b01, 30'd0}) &&
                     rsp_unit_x >= -$signed({2'b01, 30'd0}))
      )
      else $error("unit component out of range");

endmodule

### hw/rtl/vn_sqrt.sv
// Pipelined integer square root, one result bit per stage.
module vn_sqrt (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  logic [vn_pkg::SUM_W-1:0]      in_sum,
   input  vn_pkg::side_type              in_side,
   output logic                          out_valid,
   output logic [vn_pkg::COMP_W-1:0]     out_len,
   output vn_pkg::side_type              out_side
);
   import vn_pkg::*;

   logic             valid_ff [SQRT_STEPS];
   logic [SUM_W-1:0] rem_ff   [SQRT_STEPS];
   logic [SUM_W-1:0] root_ff  [SQRT_STEPS];
   side_type         side_ff  [SQRT_STEPS];

   for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
      localparam logic [SUM_W-1:0] BIT = SUM_W'(64'd1) << (62 - 2 * k);
      logic             valid_prev;
      logic [SUM_W-1:0] rem_prev;
      logic [SUM_W-1:0] root_prev;
      side_type         side_prev;
      logic [SUM_W-1:0] trial;
      logic [SUM_W-1:0] rem_in;
      logic [SUM_W-1:0] root_in;

      if (k == 0) begin : g_first
         assign valid_prev = in_valid;
         assign rem_prev   = in_sum;
         assign root_prev  = '0;
         assign side_prev  = in_side;
      end else begin : g_next
         assign valid_prev = valid_ff[k-1];
         assign rem_prev   = rem_ff[k-1];
         assign root_prev  = root_ff[k-1];
         assign side_prev  = side_ff[k-1];
      end

      always_comb begin
         trial = root_prev + BIT;
         if (rem_prev >= trial) begin
            rem_in  = rem_prev - trial;
            root_in = (root_prev >> 1) + BIT;
         end else begin
            rem_in  = rem_prev;
            root_in = root_prev >> 1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else begin
            valid_ff[k] <= valid_prev;
         end
         rem_ff[k]  <= rem_in;
         root_ff[k] <= root_in;
         side_ff[k] <= side_prev;
      end
   end

   assign out_valid = valid_ff[SQRT_STEPS-1];
   assign out_len   = root_ff[SQRT_STEPS-1][COMP_W-1:0];
   assign out_side  = side_ff[SQRT_STEPS-1];

endmodule

### hw/rtl/vn_div.sv
// Three pipelined restoring dividers that share one divisor, one quotient bit per stage.
module vn_div (
   input  logic                                            clock,
   input  logic                                            reset,
   input  logic                                            in_valid,
   input  logic [vn_pkg::COMP_W-1:0]                       in_len,
   input  vn_pkg::side_type                                in_side,
   output logic                                            out_valid,
   output logic [vn_pkg::COMP_W-1:0]                       out_len,
   output logic [vn_pkg::LANES-1:0]                        out_neg,
   output logic [vn_pkg::LANES-1:0][vn_pkg::DIV_STEPS-1:0] out_quot
);
   import vn_pkg::*;

   logic                                 valid_ff [DIV_STEPS];
   logic [COMP_W-1:0]                    len_ff   [DIV_STEPS];
   logic [LANES-1:0]                     neg_ff   [DIV_STEPS];
   logic [LANES-1:0][COMP_W:0]           rem_ff   [DIV_STEPS];
   logic [LANES-1:0][DIV_STEPS-1:0]      quot_ff  [DIV_STEPS];

   for (genvar j = 0; j < DIV_STEPS; j++) begin : g_step
      logic                            valid_prev;
      logic [COMP_W-1:0]               len_prev;
      logic [LANES-1:0]                neg_prev;
      logic [LANES-1:0][COMP_W:0]      rem_prev;
      logic [LANES-1:0][DIV_STEPS-1:0] quot_prev;
      logic [LANES-1:0][COMP_W:0]      rem_in;
      logic [LANES-1:0][DIV_STEPS-1:0] quot_in;

      if (j == 0) begin : g_first
         assign valid_prev = in_valid;
         assign len_prev   = in_len;
         assign neg_prev   = in_side.neg;
         assign quot_prev  = '0;
         for (genvar l = 0; l < LANES; l++) begin : g_lane
            assign rem_prev[l] = {1'b0, in_side.mag[l]};
         end
      end else begin : g_next
         assign valid_prev = valid_ff[j-1];
         assign len_prev   = len_ff[j-1];
         assign neg_prev   = neg_ff[j-1];
         assign quot_prev  = quot_ff[j-1];
         for (genvar l = 0; l < LANES; l++) begin : g_lane
            assign rem_prev[l] = {rem_ff[j-1][l][COMP_W-1:0], 1'b0};
         end
      end

      always_comb begin
         for (int l = 0; l < LANES; l++) begin
            if (rem_prev[l] >= {1'b0, len_prev}) begin
               rem_in[l]  = rem_prev[l] - {1'b0, len_prev};
               quot_in[l] = {quot_prev[l][DIV_STEPS-2:0], 1'b1};
            end else begin
               rem_in[l]  = rem_prev[l];
               quot_in[l] = {quot_prev[l][DIV_STEPS-2:0], 1'b0};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[j] <= 1'b0;
         end else begin
            valid_ff[j] <= valid_prev;
         end
         len_ff[j]  <= len_prev;
         neg_ff[j]  <= neg_prev;
         rem_ff[j]  <= rem_in;
         quot_ff[j] <= quot_in;
      end
   end

   assign out_valid = valid_ff[DIV_STEPS-1];
   assign out_len   = len_ff[DIV_STEPS-1];
   assign out_neg   = neg_ff[DIV_STEPS-1];
   assign out_quot  = quot_ff[DIV_STEPS-1];

endmodule

### test/vec3_normalize_test.sv
// Self-checking testbench for the vec3_normalize pipeline: predicted unit vector and length per word.
module vec3_normalize_test;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [31:0] ux;
      logic [31:0] uy;
      logic [31:0] uz;
      logic [31:0] len;
   } unit_word_type;

   class norm_scoreboard;
      unit_word_type pending[$];
      int errors;
      int checked;

      function logic [63:0] magnitude(logic [31:0] c);
         logic [63:0] m;
         m = {32'd0, c};
         if (c[31]) begin
            m = 64'h1_0000_0000 - m;
         end
         return m;
      endfunction

      function logic [63:0] int_root(logic [63:0] s);
         logic [63:0] rem;
         logic [63:0] root;
         logic [63:0] b;
         rem = s;
         root = 0;
         b = 64'd1 << 62;
         while (b != 0) begin
            if (rem >= root + b) begin
               rem = rem - (root + b);
               root = (root >> 1) + b;
            end else begin
               root = root >> 1;
            end
            b = b >> 2;
         end
         return root;
      endfunction

      function logic [31:0] unit_lane(logic [63:0] m, logic neg, logic [63:0] len);
         logic [63:0] q;
         if (len == 0) begin
            return 32'd0;
         end
         q = (m << 30) / len;
         if (q > 64'h4000_0000) begin
            q = 64'h4000_0000;
         end
         if (neg) begin
            q = 64'h1_0000_0000 - q;
         end
         return q[31:0];
      endfunction

      function void note_vector(logic [31:0] x, logic [31:0] y, logic [31:0] z);
         logic [63:0] mx;
         logic [63:0] my;
         logic [63:0] mz;
         logic [63:0] len;
         unit_word_type w;
         mx = magnitude(x);
         my = magnitude(y);
         mz = magnitude(z);
         len = int_root(mx * mx + my * my + mz * mz) & 64'hFFFF_FFFF;
         w.ux = unit_lane(mx, x[31], len);
         w.uy = unit_lane(my, y[31], len);
         w.uz = unit_lane(mz, z[31], len);
         w.len = len[31:0];
         pending.push_back(w);
      endfunction

      function void check_result(unit_word_type got);
         unit_word_type e;
         checked++;
         if (pending.size() == 0) begin
            errors++;
            $display("%0t: unexpected word ux=%h uy=%h uz=%h len=%h", $time,
                     got.ux, got.uy, got.uz, got.len);
            return;
         end
         e = pending.pop_front();
         if (got.ux !== e.ux) begin
            errors++;
            $display("%0t: unit_x expected %h actual %h", $time, e.ux, got.ux);
         end
         if (got.uy !== e.uy) begin
            errors++;
            $display("%0t: unit_y expected %h actual %h", $time, e.uy, got.uy);
         end
         if (got.uz !== e.uz) begin
            errors++;
            $display("%0t: unit_z expected %h actual %h", $time, e.uz, got.uz);
         end
         if (got.len !== e.len) begin
            errors++;
            $display("%0t: length expected %h actual %h", $time, e.len, got.len);
         end
      endfunction
   endclass

   localparam int LATENCY = 67;
   localparam int WATCHDOG_LIMIT = 2000;

   logic clock = 0;
   logic reset = 1;
   logic start = 0;
   logic busy;
   logic signed [31:0] req_comp_x = 0;
   logic signed [31:0] req_comp_y = 0;
   logic signed [31:0] req_comp_z = 0;
   logic rsp_valid;
   logic signed [31:0] rsp_unit_x;
   logic signed [31:0] rsp_unit_y;
   logic signed [31:0] rsp_unit_z;
   logic [31:0] rsp_vector_length;

   norm_scoreboard board = new();
   int idle_cycles = 0;
   int sent = 0;

   always #4 clock = ~clock;

   vec3_normalize dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_comp_x(req_comp_x), .req_comp_y(req_comp_y), .req_comp_z(req_comp_z),
      .rsp_valid(rsp_valid), .rsp_unit_x(rsp_unit_x), .rsp_unit_y(rsp_unit_y),
      .rsp_unit_z(rsp_unit_z), .rsp_vector_length(rsp_vector_length)
   );

   always @(posedge clock) begin
      unit_word_type got;
      if (!reset) begin
         if (start && !busy) begin
            board.note_vector(req_comp_x, req_comp_y, req_comp_z);
         end
         if (rsp_valid) begin
            got.ux = rsp_unit_x;
            got.uy = rsp_unit_y;
            got.uz = rsp_unit_z;
            got.len = rsp_vector_length;
            board.check_result(got);
         end
         if ((start && !busy) || rsp_valid) begin
            idle_cycles <= 0;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   always @(posedge clock) begin
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   function logic [31:0] random_component();
      case ($urandom_range(0, 5))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return $urandom_range(0, 3) - 1;
         3: return 32'($signed($urandom_range(0, 255)) - 128);
         4: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
         default: return $urandom;
      endcase
   endfunction

   task automatic send_vector(logic [31:0] x, logic [31:0] y, logic [31:0] z);
      int gap;
      req_comp_x <= x;
      req_comp_y <= y;
      req_comp_z <= z;
      start <= 1;
      do @(posedge clock); while (busy);
      sent++;
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
      if ($urandom_range(0, 3) == 0) begin
         gap = 0;
      end
      if (gap > 0) begin
         start <= 0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      start <= 0;
      @(posedge clock);
      while (board.pending.size() != 0) @(posedge clock);
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      send_vector(0, 0, 0);
      send_vector(32'h8000_0000, 0, 0);
      send_vector(32'h7FFF_FFFF, 0, 0);
      send_vector(0, 32'h8000_0000, 0);
      send_vector(0, 0, 32'h8000_0000);
      send_vector(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      send_vector(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_vector(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
      send_vector(1, 0, 0);
      send_vector(32'hFFFF_FFFF, 0, 0);
      send_vector(1, 1, 1);
      send_vector(32'hFFFF_FFFF, 1, 32'hFFFF_FFFF);
      send_vector(3, 4, 0);
      send_vector(32'h0001_0000, 32'h0001_0000, 0);
      send_vector(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_vector(32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_0F0F);
      send_vector(2, 3, 32'hFFFF_FFFA);
      wait_drained();
      for (int i = 0; i < 600; i++) begin
         send_vector(random_component(), random_component(), random_component());
         if (i == 300) begin
            wait_drained();
         end
      end
      wait_drained();
      repeat (LATENCY + 10) @(posedge clock);
      $display("Sent %0d vectors and checked %0d results, covering zero, extreme and", sent,
               board.checked);
      $display("small-magnitude components with random idle gaps and a full drain.");
      if (board.errors == 0 && board.pending.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end
endmodule
